// ----- src/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the pooling block checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("lbl failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error("lbl failed");

`endif

// ----- src/wpf_pkg.sv -----
// ---------------------------------------------------------------------------
// Window pooling package
// Types and constants shared by the pooling front end, back end and top level.
// ---------------------------------------------------------------------------
package wpf_pkg;

  localparam int MaxWidth   = 256;
  localparam int MaxKernel  = 8;
  localparam int SampleBits = 16;
  localparam int PlaneMax   = 256;
  localparam int StoreDepth = MaxWidth * MaxKernel;
  localparam int AddrBits   = $clog2(StoreDepth);
  localparam int ColBits    = $clog2(MaxWidth);
  localparam int RowSelBits = $clog2(MaxKernel);
  localparam int QueueDepth = 4;

  localparam logic [2:0] RegMode      = 3'd0;
  localparam logic [2:0] RegKernel    = 3'd1;
  localparam logic [2:0] RegStride    = 3'd2;
  localparam logic [2:0] RegInWidth   = 3'd3;
  localparam logic [2:0] RegInHeight  = 3'd4;
  localparam logic [2:0] RegOutWidth  = 3'd5;
  localparam logic [2:0] RegOutHeight = 3'd6;

  // One window job handed from front to back.
  typedef struct packed {
    logic [ColBits-1:0]    x0;
    logic [7:0]            y0;
    logic [3:0]            k;
    logic                  mode;
    logic                  last;
  } job_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkRead,
    BkDrain,
    BkOut
  } bk_state_e;

endpackage

// ----- src/wpf_ram.sv -----
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module wpf_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- src/wpf_front.sv -----
// ---------------------------------------------------------------------------
// Pooling front end
// Tracks raster position, writes samples to the line store and issues
// window jobs when a sample completes a window on the stride grid.
// ---------------------------------------------------------------------------
module wpf_front import wpf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           k_i,
  input  logic [3:0]           s_i,
  input  logic [8:0]           w_i,
  input  logic [8:0]           h_i,
  input  logic [8:0]           ow_i,
  input  logic [8:0]           oh_i,
  input  logic                 mode_i,
  input  logic                 in_fire_i,
  input  logic [SampleBits-1:0] sample_i,
  output logic                 we_o,
  output logic [AddrBits-1:0]  waddr_o,
  output logic [SampleBits-1:0] wdata_o,
  output logic                 job_valid_o,
  output job_t                 job_o
);

  logic [8:0] col_q, col_d, row_q, row_d;
  logic [3:0] sx_q, sx_d, sy_q, sy_d;
  logic [8:0] wx_q, wx_d, wy_q, wy_d;
  logic       xok, yok, hit;

  // Reach counts windows along an axis as positions on the stride grid.
  assign xok = (col_q + 9'd1 >= {5'd0, k_i}) && (sx_q == 4'd0) && (wx_q < ow_i);
  assign yok = (row_q + 9'd1 >= {5'd0, k_i}) && (sy_q == 4'd0) && (wy_q < oh_i);
  assign hit = in_fire_i && xok && yok;

  assign we_o    = in_fire_i;
  assign waddr_o = {row_q[RowSelBits-1:0], col_q[ColBits-1:0]};
  assign wdata_o = sample_i;

  always_comb begin
    col_d = col_q; row_d = row_q; sx_d = sx_q; sy_d = sy_q; wx_d = wx_q; wy_d = wy_q;
    if (in_fire_i) begin
      if (col_q + 9'd1 >= {5'd0, k_i}) begin
        if (sx_q == 4'd0) begin
          if (wx_q != 9'h1ff) wx_d = wx_q + 9'd1;
          sx_d = (s_i == 4'd1) ? 4'd0 : s_i - 4'd1;
        end else begin
          sx_d = sx_q - 4'd1;
        end
      end
      if (col_q + 9'd1 >= w_i) begin
        col_d = '0; sx_d = '0; wx_d = '0;
        if (row_q + 9'd1 >= {5'd0, k_i}) begin
          if (sy_q == 4'd0) begin
            if (wy_q != 9'h1ff) wy_d = wy_q + 9'd1;
            sy_d = (s_i == 4'd1) ? 4'd0 : s_i - 4'd1;
          end else begin
            sy_d = sy_q - 4'd1;
          end
        end
        if (row_q + 9'd1 >= h_i) begin
          row_d = '0; sy_d = '0; wy_d = '0;
        end else begin
          row_d = row_q + 9'd1;
        end
      end else begin
        col_d = col_q + 9'd1;
      end
    end
    if (cfg_we_i) begin
      col_d = '0; row_d = '0; sx_d = '0; sy_d = '0; wx_d = '0; wy_d = '0;
    end
  end

  // A window is last when no further window fits in either direction.
  logic lastx, lasty;
  assign lastx = (wx_q + 9'd1 == ow_i) ||
                 ({1'b0, col_q} + 10'd1 + {6'd0, s_i} > {1'b0, w_i});
  assign lasty = (wy_q + 9'd1 == oh_i) ||
                 ({1'b0, row_q} + 10'd1 + {6'd0, s_i} > {1'b0, h_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0; row_q <= '0; sx_q <= '0; sy_q <= '0; wx_q <= '0; wy_q <= '0;
      job_valid_o <= 1'b0;
    end else begin
      col_q <= col_d; row_q <= row_d; sx_q <= sx_d; sy_q <= sy_d;
      wx_q <= wx_d; wy_q <= wy_d;
      job_valid_o <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      job_o.x0   <= ColBits'(col_q + 9'd1 - {5'd0, k_i});
      job_o.y0   <= 8'(row_q + 9'd1 - {5'd0, k_i});
      job_o.k    <= k_i;
      job_o.mode <= mode_i;
      job_o.last <= lastx && lasty;
    end
  end

endmodule

// ----- src/wpf_back.sv -----
// ---------------------------------------------------------------------------
// Pooling back end
// Pops window jobs, reads the window from the line store one entry a cycle,
// reduces it and holds the result for the output channel.
// ---------------------------------------------------------------------------
module wpf_back import wpf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  job_valid_i,
  input  job_t                  job_i,
  output logic                  job_pop_o,
  output logic                  reading_o,
  output logic [AddrBits-1:0]   raddr_o,
  input  logic [SampleBits-1:0] rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SampleBits-1:0] value_o,
  output logic [5:0]            index_o,
  output logic                  last_o
);

  bk_state_e state_q, state_d;
  job_t      job_q;
  logic [2:0] cx_q, cy_q;
  logic [5:0] cnt_q, rc_q;
  logic       rv_q;
  logic signed [SampleBits+6:0] sum_q;
  logic signed [SampleBits-1:0] best_q;
  logic [5:0] bidx_q;
  logic [6:0] kk;
  logic       neg_q;
  logic [SampleBits+6:0] mag;
  logic [4:0] dbit_q;
  logic       div_go_q, mag_done;
  logic [SampleBits+6:0] dq_q, dr_q;
  logic [SampleBits+7:0] trial;

  assign kk        = {3'd0, job_q.k} * {3'd0, job_q.k};
  assign raddr_o   = {3'(job_q.y0 + {5'd0, cy_q}), ColBits'(job_q.x0 + {5'd0, cx_q})};
  assign job_pop_o = (state_q == BkIdle) && job_valid_i;
  assign reading_o = (state_q == BkRead);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle:  if (job_valid_i) state_d = BkRead;
      BkRead:  if (cnt_q + 6'd1 == kk[5:0] || kk == 7'd64 && cnt_q == 6'd63) state_d = BkDrain;
      BkDrain: if (!rv_q && mag_done) state_d = BkOut;
      BkOut:   if (out_ready_i) state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  // Mean division: restoring, one quotient bit per cycle.
  assign mag_done = div_go_q && (dbit_q == 5'd0);
  assign mag = sum_q[SampleBits+6] ? unsigned'(-sum_q) : unsigned'(sum_q);

  always_comb begin
    out_valid_o = (state_q == BkOut);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q <= (state_q == BkRead);
    end
  end

  assign trial = {dr_q, dq_q[SampleBits+6]} - {17'd0, kk};

  always_ff @(posedge clk_i) begin
    case (state_q)
      BkIdle: begin
        job_q <= job_i; cx_q <= '0; cy_q <= '0; cnt_q <= '0; rc_q <= '0;
        sum_q <= '0; best_q <= '0; bidx_q <= '0; div_go_q <= 1'b0;
      end
      BkRead: begin
        cnt_q <= cnt_q + 6'd1;
        if (cx_q + 3'd1 == 3'(job_q.k) || job_q.k == 4'd8 && cx_q == 3'd7) begin
          cx_q <= '0; cy_q <= cy_q + 3'd1;
        end else begin
          cx_q <= cx_q + 3'd1;
        end
      end
      default: ;
    endcase
    if (rv_q) begin
      sum_q <= sum_q + (SampleBits+7)'(signed'(rdata_i));
      if (signed'(rdata_i) > best_q) begin
        best_q <= rdata_i; bidx_q <= rc_q;
      end
      rc_q <= rc_q + 6'd1;
    end
    if (state_q == BkDrain && !rv_q && !div_go_q) begin
      div_go_q <= 1'b1; dbit_q <= 5'd23; dq_q <= mag; dr_q <= '0;
      neg_q <= sum_q[SampleBits+6];
    end else if (div_go_q && dbit_q != 5'd0) begin
      dbit_q <= dbit_q - 5'd1;
      if (!trial[SampleBits+7]) begin
        dr_q <= trial[SampleBits+6:0]; dq_q <= {dq_q[SampleBits+5:0], 1'b1};
      end else begin
        dr_q <= {dr_q[SampleBits+5:0], dq_q[SampleBits+6]};
        dq_q <= {dq_q[SampleBits+5:0], 1'b0};
      end
    end
    if (state_q == BkDrain && state_d == BkOut) begin
      value_o <= job_q.mode ? SampleBits'(neg_q ? -dq_q : dq_q) : best_q;
      index_o <= job_q.mode ? 6'd0 : bidx_q;
      last_o  <= job_q.last;
    end
  end

endmodule

// ----- src/window_pooling_forward.sv -----
// ---------------------------------------------------------------------------
// Window pooling forward
// Streaming max or mean pooling of one feature-map plane.
// ---------------------------------------------------------------------------
// Samples enter on the s_axis channel in raster order, one request per cycle
// while s_axis_tready is high. Each sample is written into an eight-row line
// store. A sample that closes a window on the stride grid queues a job; the
// back end reads the k*k window from the store one entry per cycle, then runs
// a restoring divider whose quotient is used in mean mode. After the closing
// sample is accepted, its job is registered and queued, then passes the back
// end's read and drain states, set by the single read port and the bit-serial
// divider, before the result is valid. Samples that close no window are
// accepted back to back. After a closing sample, input pauses while the job is
// queued and its window is read, so no later sample overwrites the window. A
// further closing sample waits in the queue, with input held, until the back
// end is free. Results leave on m_axis and are held while the receiver stalls;
// input keeps flowing until a second window job is waiting.
// Reset clears the raster counters and the job queue and idles the back end; registers return to their defaults.
// Any register write restarts the plane. Write config only when idle.
// ---------------------------------------------------------------------------
module window_pooling_forward import wpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [15:0] pooled_value, [21:16] window_index
  output logic        m_axis_tlast    // last_of_plane
);

  logic       mode_q;
  logic [3:0] k_q, s_q;
  logic [8:0] w_q, h_q, ow_q, oh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; k_q <= 4'd2; s_q <= 4'd2;
      w_q <= 9'd256; h_q <= 9'd256; ow_q <= 9'd128; oh_q <= 9'd128;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:      mode_q <= cfg_data_i[0];
        RegKernel:    k_q <= cfg_data_i[3:0];
        RegStride:    s_q <= cfg_data_i[3:0];
        RegInWidth:   w_q <= cfg_data_i;
        RegInHeight:  h_q <= cfg_data_i;
        RegOutWidth:  ow_q <= cfg_data_i;
        RegOutHeight: oh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0] ke, se;
  logic [8:0] we, he, owe, ohe;
  assign ke  = (k_q == 4'd0) ? 4'd1 : (k_q > 4'(MaxKernel)) ? 4'(MaxKernel) : k_q;
  assign se  = (s_q == 4'd0) ? 4'd1 : s_q;
  assign we  = (w_q == 9'd0) ? 9'd1 : (w_q > 9'(MaxWidth)) ? 9'(MaxWidth) : w_q;
  assign he  = (h_q == 9'd0) ? 9'd1 : (h_q > 9'(PlaneMax)) ? 9'(PlaneMax) : h_q;
  assign owe = (ow_q == 9'd0) ? 9'd1 : (ow_q > 9'(PlaneMax)) ? 9'(PlaneMax) : ow_q;
  assign ohe = (oh_q == 9'd0) ? 9'd1 : (oh_q > 9'(PlaneMax)) ? 9'(PlaneMax) : oh_q;

  logic in_fire, jv, pop, ram_we, reading, cfg_hit;
  job_t jd;
  logic [AddrBits-1:0] wa, ra;
  logic [SampleBits-1:0] wd, rd;

  job_t      fifo_q [QueueDepth];
  logic [2:0] cnt_q;
  logic [1:0] wp_q, rp_q;

  assign cfg_hit = cfg_we_i && (cfg_index_i inside {[RegMode:RegOutHeight]});
  assign s_axis_tready = (cnt_q == 3'd0) && !jv && !reading;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  wpf_front u_front (
    .clk_i, .rst_ni, .cfg_we_i(cfg_hit), .k_i(ke), .s_i(se), .w_i(we), .h_i(he),
    .ow_i(owe), .oh_i(ohe), .mode_i(mode_q), .in_fire_i(in_fire),
    .sample_i(s_axis_tdata), .we_o(ram_we), .waddr_o(wa), .wdata_o(wd),
    .job_valid_o(jv), .job_o(jd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= '0; rp_q <= '0;
    end else begin
      if (jv) wp_q <= wp_q + 2'd1;
      if (pop) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'd0, jv} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (jv) fifo_q[wp_q] <= jd;
  end

  wpf_ram #(.Width(SampleBits), .Depth(StoreDepth)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  logic [15:0] val;
  logic [5:0]  idx;

  wpf_back u_back (
    .clk_i, .rst_ni, .job_valid_i(cnt_q != 3'd0), .job_i(fifo_q[rp_q]),
    .job_pop_o(pop), .reading_o(reading), .raddr_o(ra), .rdata_i(rd),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .value_o(val),
    .index_o(idx), .last_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, idx, val};

endmodule

// ----- src/wpf_checker.sv -----
// ---------------------------------------------------------------------------
// Window pooling checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wpf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ASSERT_NEXT(a_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `ASSERT_IMPL(a_pad, clk_i, rst_ni, m_axis_tdata[23:22] == 2'b00)

endmodule

bind window_pooling_forward wpf_checker u_chk (.*);

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// Window pooling forward testbench
// Streams feature-map planes through the pooling block under several
// register settings and compares every window result with a predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class pool_scoreboard;
  logic [15:0] line_mem [0:2047];
  int unsigned col, row;
  int unsigned mode_r, kern_r, strd_r, inw_r, inh_r, outw_r, outh_r;
  logic [15:0] exp_value [$];
  logic [5:0]  exp_index [$];
  logic        exp_last [$];
  int errors;

  function void reset_state();
    mode_r = 0; kern_r = 2; strd_r = 2; inw_r = 256; inh_r = 256;
    outw_r = 128; outh_r = 128;
    col = 0; row = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [8:0] val);
    case (idx)
      wpf_pkg::RegMode:      mode_r = val[0];
      wpf_pkg::RegKernel:    kern_r = val[3:0];
      wpf_pkg::RegStride:    strd_r = val[3:0];
      wpf_pkg::RegInWidth:   inw_r = val;
      wpf_pkg::RegInHeight:  inh_r = val;
      wpf_pkg::RegOutWidth:  outw_r = val;
      wpf_pkg::RegOutHeight: outh_r = val;
      default: return;
    endcase
    col = 0; row = 0;
  endfunction

  function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function int unsigned axis_count(int unsigned len, int unsigned olen,
                                   int unsigned k, int unsigned s);
    int unsigned n;
    olen = clip(olen, 1, 256);
    if (k > len) return 0;
    n = (len - k) / s + 1;
    return n < olen ? n : olen;
  endfunction

  function void note_sample(logic [15:0] smp);
    int unsigned k, s, w, h, x, y, ow, oh, x0, y0, c, bidx;
    longint best, sum, v, res;
    k = clip(kern_r, 1, 8);
    s = strd_r == 0 ? 1 : strd_r;
    w = clip(inw_r, 1, 256);
    h = clip(inh_r, 1, 256);
    x = col; y = row;
    ow = axis_count(w, outw_r, k, s);
    oh = axis_count(h, outh_r, k, s);
    if (x >= w) x = w - 1;
    line_mem[(y % 8) * 256 + x] = smp;
    if (x + 1 >= k && y + 1 >= k && (x + 1 - k) % s == 0 && (y + 1 - k) % s == 0 &&
        (x + 1 - k) / s < ow && (y + 1 - k) / s < oh) begin
      x0 = x + 1 - k; y0 = y + 1 - k;
      c = 0; bidx = 0; best = 0; sum = 0;
      for (int cy = 0; cy < k; cy++) begin
        for (int cx = 0; cx < k; cx++) begin
          v = $signed(line_mem[((y0 + cy) % 8) * 256 + x0 + cx]);
          sum += v;
          if (v > best) begin
            best = v;
            bidx = c;
          end
          c++;
        end
      end
      if (mode_r == 0) begin
        res = best;
      end else begin
        res = sum / longint'(k * k);
        bidx = 0;
      end
      exp_value.push_back(res[15:0]);
      exp_index.push_back(bidx[5:0]);
      exp_last.push_back((x0 / s) + 1 == ow && (y0 / s) + 1 == oh);
    end
    if (x + 1 >= w) begin
      col = 0;
      row = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col = x + 1;
    end
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_window(logic [23:0] data, logic last);
    if (exp_value.size() == 0) begin
      report($sformatf("unexpected result %h", data));
      return;
    end
    if (data[15:0] !== exp_value[0])
      report($sformatf("value %h expected %h", data[15:0], exp_value[0]));
    if (data[21:16] !== exp_index[0])
      report($sformatf("index %0d expected %0d", data[21:16], exp_index[0]));
    if (last !== exp_last[0])
      report($sformatf("last %b expected %b", last, exp_last[0]));
    void'(exp_value.pop_front());
    void'(exp_index.pop_front());
    void'(exp_last.pop_front());
  endtask
endclass

module testbench;
  import wpf_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [15:0] in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [23:0] out_data;
  logic        out_last;
  bit          stall_free = 0;
  bit          stim_done = 0;
  pool_scoreboard windows = new();

  always #5 clk = ~clk;

  window_pooling_forward i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
    .m_axis_tvalid(out_valid), .m_axis_tready(out_ready),
    .m_axis_tdata(out_data), .m_axis_tlast(out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) windows.check_window(out_data, out_last);
  end

  always @(negedge clk) begin
    out_ready <= stall_free || ($urandom_range(0, 99) >= 25);
  end

  task write_reg(logic [2:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    windows.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task send_sample(logic [15:0] smp);
    while (!stall_free && $urandom_range(0, 99) < 25) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_data <= smp;
    do @(posedge clk); while (!in_ready);
    windows.note_sample(smp);
    @(negedge clk);
  endtask

  task drain();
    in_valid <= 0;
    while (windows.exp_value.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task set_geometry(int md, int k, int s, int iw, int ih, int ow, int oh);
    write_reg(RegMode, 9'(md)); write_reg(RegKernel, 9'(k)); write_reg(RegStride, 9'(s));
    write_reg(RegInWidth, 9'(iw)); write_reg(RegInHeight, 9'(ih));
    write_reg(RegOutWidth, 9'(ow)); write_reg(RegOutHeight, 9'(oh));
  endtask

  initial begin
    int sent, iw, ih;
    windows.reset_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // Directed: 2x2 max, extremes, all-negative window, ties, then mean.
    set_geometry(0, 2, 2, 4, 2, 2, 1);
    send_sample(16'h8000); send_sample(16'hffff); send_sample(16'h0100);
    send_sample(16'h0100); send_sample(16'hff00); send_sample(16'h8000);
    send_sample(16'h0100); send_sample(16'h7fff);
    drain();
    set_geometry(1, 2, 2, 4, 2, 2, 1);
    send_sample(16'h8000); send_sample(16'h8000); send_sample(16'h7fff);
    send_sample(16'h0003); send_sample(16'h8000); send_sample(16'h8000);
    send_sample(16'h7fff); send_sample(16'hfffd);
    drain();
    // Out-of-range registers: kernel 0, stride 0, kernel beyond plane.
    set_geometry(0, 0, 0, 3, 1, 511, 0);
    send_sample(16'h1234); send_sample(16'hedcb); send_sample(16'h0001);
    drain();
    set_geometry(1, 15, 15, 4, 4, 4, 4);
    repeat (4) send_sample(rand_sample());
    drain();
    // Random planes; the first stretch runs with no random idles or output stalls.
    sent = 0;
    stall_free = 1;
    while (sent < 1700) begin
      if (sent > 250) stall_free = 0;
      iw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 16);
      ih = $urandom_range(1, 12);
      set_geometry($urandom_range(0, 1), $urandom_range(0, 9), $urandom_range(0, 9),
                   iw, ih, $urandom_range(0, 20), $urandom_range(0, 20));
      if (iw > 256) iw = 256;
      for (int n = 0; n < iw * ih && sent < 1700; n++) begin
        send_sample(rand_sample());
        sent++;
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (windows.errors == 0 && windows.exp_value.size() == 0) begin
      $display("window_pooling_forward test passed");
    end else begin
      $display("window_pooling_forward test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("window_pooling_forward test failed");
    $finish;
  end
endmodule
